/* sv/spq_pkg.sv */
// Shared constants and types of the sorted priority queue.
// Used by the channel interfaces and by the core module of the block.
`default_nettype none

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int COUNT_W = 5;
	localparam int COUNT_MAX = 31;
	localparam int KEY_W = 32;

	localparam logic signed [KEY_W-1:0] EMPTY_MARK = 32'sh7FFF_FFFF;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef struct packed {
		logic signed [KEY_W-1:0] prio;
		logic signed [KEY_W-1:0] data;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* sv/spq_req_if.sv */
// Request channel of the sorted priority queue: valid, ready and the request fields.
// Depends on spq_pkg for the key width.
`default_nettype none

interface spq_req_if;
	import spq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [KEY_W-1:0] new_priority;
	logic signed [KEY_W-1:0] new_data;

	modport source (output valid, output req_type, output new_priority, output new_data,
		input ready);
	modport sink (input valid, input req_type, input new_priority, input new_data,
		output ready);

endinterface

`default_nettype wire

/* sv/spq_rsp_if.sv */
// Response channel of the sorted priority queue: valid, ready and the result fields.
// Depends on spq_pkg for the key and count widths.
`default_nettype none

interface spq_rsp_if;
	import spq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [KEY_W-1:0] head_data;
	logic signed [KEY_W-1:0] head_priority;
	logic                    queue_empty;
	logic [COUNT_W-1:0]      compare_count;
	logic                    insert_dropped;

	modport source (output valid, output head_data, output head_priority, output queue_empty,
		output compare_count, output insert_dropped, input ready);
	modport sink (input valid, input head_data, input head_priority, input queue_empty,
		input compare_count, input insert_dropped, output ready);

endinterface

`default_nettype wire

/* sv/spq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; width and depth come from its parameters.
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/sorted_priority_queue_core.sv */
// Sorted priority queue core: a sequencer around one entry RAM and one key comparator.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_ram.
//
// The queue holds up to CAPACITY (priority, data) entries in ascending priority order in a
// single RAM, equal priorities in arrival order. One entry is read per cycle, and an insert
// compares each one it reads. An insert walks from the tail toward the head, moving each
// larger entry up by one slot. A delete removes the head and moves every other entry
// down by one slot. The RAM's single write port and registered read set the pace of these
// walks. The request side is ready only while the sequencer is idle; a finished
// transaction waits in the response register without holding back the next request.
`default_nettype none

module sorted_priority_queue_core (
	input wire logic clk,
	input wire logic arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CW = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_UP,
		ST_PLACE,
		ST_SHIFT_DN,
		ST_HEAD,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        occ_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] prio_q;
	logic signed [KEY_W-1:0] data_q;
	logic [COUNT_W-1:0]      count_q;
	logic                    dropped_q;

	logic                    rsp_valid_q;
	logic signed [KEY_W-1:0] head_data_q;
	logic signed [KEY_W-1:0] head_prio_q;
	logic                    empty_q;
	logic [COUNT_W-1:0]      rsp_count_q;
	logic                    rsp_dropped_q;

	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic [ENTRY_W-1:0]      mem_wdata;
	logic [ADDR_W-1:0]       mem_raddr;
	logic [ENTRY_W-1:0]      mem_rdata;
	entry_t                  rd_entry;
	entry_t                  new_entry;
	logic                    move_up;
	logic                    accept;
	logic                    rsp_load;
	logic [IDX_W-1:0]        ptr_inc;
	logic [IDX_W-1:0]        ptr_dec;
	logic [IDX_W-1:0]        occ_dec;

	function automatic logic [COUNT_W-1:0] count_of(input logic [IDX_W-1:0] k,
		input logic [IDX_W-1:0] occ);
		logic [CW-1:0] c;
		c = '0;
		if (occ != '0) begin
			c = (k < occ) ? CW'(k) + CW'(1) : CW'(k);
		end
		if (c > CW'(COUNT_MAX)) begin
			c = CW'(COUNT_MAX);
		end
		return COUNT_W'(c);
	endfunction

	spq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_entry  = entry_t'(mem_rdata);
	assign new_entry = '{prio: prio_q, data: data_q};
	assign move_up   = rd_entry.prio > prio_q;
	assign accept    = req.valid && req.ready;
	assign rsp_load  = (state_q == ST_OUT) && (!rsp_valid_q || rsp.ready);
	assign ptr_inc   = ptr_q + IDX_W'(1);
	assign ptr_dec   = ptr_q - IDX_W'(1);
	assign occ_dec   = occ_q - IDX_W'(1);

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.head_data      = head_data_q;
	assign rsp.head_priority  = head_prio_q;
	assign rsp.queue_empty    = empty_q;
	assign rsp.compare_count  = rsp_count_q;
	assign rsp.insert_dropped = rsp_dropped_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = ENTRY_W'(new_entry);
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.req_type == REQ_INSERT && occ_q != '0 && occ_q < IDX_W'(CAPACITY)) begin
					mem_raddr = ADDR_W'(occ_dec);
				end else if (req.req_type == REQ_DELETE) begin
					mem_raddr = ADDR_W'(1);
				end
			end
			ST_SHIFT_UP: begin
				mem_raddr = (ptr_q == '0) ? '0 : ADDR_W'(ptr_dec);
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(ptr_inc);
				mem_wdata = move_up ? ENTRY_W'(rd_entry) : ENTRY_W'(new_entry);
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(pos_q);
			end
			ST_SHIFT_DN: begin
				if (ptr_q < occ_q) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(ptr_dec);
					mem_wdata = ENTRY_W'(rd_entry);
					mem_raddr = (ptr_inc < occ_q) ? ADDR_W'(ptr_inc) : '0;
				end
			end
			ST_HEAD: begin
				mem_raddr = '0;
			end
			ST_OUT: begin
				mem_raddr = '0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			occ_q         <= '0;
			ptr_q         <= '0;
			pos_q         <= '0;
			count_q       <= '0;
			dropped_q     <= 1'b0;
			rsp_valid_q   <= 1'b0;
			empty_q       <= 1'b1;
			rsp_count_q   <= '0;
			rsp_dropped_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prio_q    <= req.new_priority;
						data_q    <= req.new_data;
						count_q   <= '0;
						dropped_q <= 1'b0;
						if (req.req_type == REQ_INSERT) begin
							if (occ_q >= IDX_W'(CAPACITY)) begin
								dropped_q <= 1'b1;
								state_q   <= ST_HEAD;
							end else if (occ_q == '0) begin
								pos_q   <= '0;
								state_q <= ST_PLACE;
							end else begin
								ptr_q   <= occ_dec;
								state_q <= ST_SHIFT_UP;
							end
						end else begin
							if (occ_q == '0) begin
								state_q <= ST_HEAD;
							end else begin
								ptr_q   <= IDX_W'(1);
								state_q <= ST_SHIFT_DN;
							end
						end
					end
				end
				ST_SHIFT_UP: begin
					if (move_up) begin
						if (ptr_q == '0) begin
							pos_q   <= '0;
							state_q <= ST_PLACE;
						end else begin
							ptr_q <= ptr_dec;
						end
					end else begin
						count_q <= count_of(ptr_inc, occ_q);
						occ_q   <= occ_q + IDX_W'(1);
						state_q <= ST_HEAD;
					end
				end
				ST_PLACE: begin
					count_q <= count_of(pos_q, occ_q);
					occ_q   <= occ_q + IDX_W'(1);
					state_q <= ST_HEAD;
				end
				ST_SHIFT_DN: begin
					if (ptr_q < occ_q) begin
						ptr_q <= ptr_inc;
					end else begin
						occ_q   <= occ_dec;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp_load) begin
						empty_q       <= (occ_q == '0);
						head_data_q   <= (occ_q == '0) ? EMPTY_MARK : rd_entry.data;
						head_prio_q   <= (occ_q == '0) ? EMPTY_MARK : rd_entry.prio;
						rsp_count_q   <= count_q;
						rsp_dropped_q <= dropped_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= IDX_W'(CAPACITY))
		else $error("occupancy exceeds capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request side ready right after a transaction");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (IDX_W'(mem_waddr) < occ_q + IDX_W'(1)))
		else $error("entry write beyond the occupied region");

	a_drop_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_dropped_q |-> rsp_count_q == '0)
		else $error("refused insert reports comparisons");

	a_empty_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && empty_q |-> head_prio_q == EMPTY_MARK && head_data_q == EMPTY_MARK)
		else $error("empty queue without the empty mark");

endmodule

`default_nettype wire
